FILE: sv/rbs_pkg.sv
// Shared constants for the ray/box slab hit test.
package rbs_pkg;
  localparam int unsigned NUM_AXES = 3;
endpackage

FILE: sv/rbs_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
module rbs_div #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic signed [CW:0]   num_i,
  input  logic signed [CW-1:0] den_i,
  output logic signed [CW-1:0] q_o
);
  localparam int unsigned QW = CW + 1 + FB;

  logic [CW-1:0] rem_q [0:QW];
  logic [QW-1:0] nq_q  [0:QW];
  logic [CW-1:0] den_q [0:QW];
  logic          neg_q [0:QW];
  logic [CW:0]   un;
  logic [CW-1:0] ud;
  logic          sat;
  logic [CW-1:0] mag;
  logic signed [CW-1:0] q_d;
  logic signed [CW-1:0] q_q;

  assign un = num_i[CW] ? (~num_i) + 1'b1 : num_i;
  assign ud = den_i[CW-1] ? (~den_i) + 1'b1 : den_i;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    nq_q[0]  <= {un, {FB{1'b0}}};
    den_q[0] <= ud;
    neg_q[0] <= num_i[CW] ^ den_i[CW-1];
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [CW:0] trial;
    logic        ge;
    assign trial = {rem_q[s], nq_q[s][QW-1]};
    assign ge    = trial >= {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? CW'(trial - {1'b0, den_q[s]}) : trial[CW-1:0];
      nq_q[s+1]  <= {nq_q[s][QW-2:0], ge};
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
    end
  end

  assign sat = |nq_q[QW][QW-1:CW-1];
  assign mag = nq_q[QW][CW-1:0];

  always_comb begin
    if (neg_q[QW]) begin
      q_d = sat ? {1'b1, {(CW-1){1'b0}}} : $signed((~mag) + 1'b1);
    end else begin
      q_d = sat ? {1'b0, {(CW-1){1'b1}}} : $signed(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;
endmodule

FILE: sv/rbs_lane.sv
// One axis lane: slab differences, two dividers, parallel-axis check, ordering.
module rbs_lane #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic signed [CW-1:0] o_i,
  input  logic signed [CW-1:0] d_i,
  input  logic signed [CW-1:0] lo_i,
  input  logic signed [CW-1:0] hi_i,
  output logic signed [CW-1:0] tn_o,
  output logic signed [CW-1:0] tf_o,
  output logic                 miss_o
);
  localparam int unsigned QW = CW + 1 + FB;
  // difference register, divider input register, QW stages, divider output register
  localparam int unsigned DL = QW + 3;

  logic signed [CW:0]   dlo_q, dhi_q;
  logic signed [CW-1:0] d_q;
  logic [DL-1:0]        par_q, miss_q;
  logic signed [CW-1:0] t1, t2;
  logic signed [CW-1:0] tn_q, tf_q;
  logic                 miss_o_q;
  logic                 par_d, miss_d;

  assign par_d  = d_i == '0;
  assign miss_d = par_d && ((o_i < lo_i) || (o_i > hi_i));

  always_ff @(posedge clk_i) begin
    dlo_q  <= $signed({lo_i[CW-1], lo_i}) - $signed({o_i[CW-1], o_i});
    dhi_q  <= $signed({hi_i[CW-1], hi_i}) - $signed({o_i[CW-1], o_i});
    d_q    <= par_d ? $signed({{(CW-1){1'b0}}, 1'b1}) : d_i;
    par_q  <= {par_q[DL-2:0], par_d};
    miss_q <= {miss_q[DL-2:0], miss_d};
  end

  rbs_div #(.CW(CW), .FB(FB)) u_div_lo (
    .clk_i (clk_i),
    .num_i (dlo_q),
    .den_i (d_q),
    .q_o   (t1)
  );

  rbs_div #(.CW(CW), .FB(FB)) u_div_hi (
    .clk_i (clk_i),
    .num_i (dhi_q),
    .den_i (d_q),
    .q_o   (t2)
  );

  always_ff @(posedge clk_i) begin
    if (par_q[DL-1]) begin
      tn_q <= {1'b1, {(CW-1){1'b0}}};
      tf_q <= {1'b0, {(CW-1){1'b1}}};
    end else if (t1 > t2) begin
      tn_q <= t2;
      tf_q <= t1;
    end else begin
      tn_q <= t1;
      tf_q <= t2;
    end
    miss_o_q <= miss_q[DL-1];
  end

  assign tn_o   = tn_q;
  assign tf_o   = tf_q;
  assign miss_o = miss_o_q;
endmodule

FILE: sv/rbs_merge.sv
// Merges lane results: near maximum, far minimum, final hit decision.
module rbs_merge #(
  parameter int unsigned CW = 32
) (
  input  logic                 clk_i,
  input  logic signed [CW-1:0] tn_i   [rbs_pkg::NUM_AXES],
  input  logic signed [CW-1:0] tf_i   [rbs_pkg::NUM_AXES],
  input  logic                 miss_i [rbs_pkg::NUM_AXES],
  output logic                 hit_o
);
  import rbs_pkg::*;

  logic signed [CW-1:0] near_d, far_d, near_q, far_q;
  logic                 miss_d, miss_q, hit_q;

  always_comb begin
    near_d = tn_i[0];
    far_d  = tf_i[0];
    miss_d = miss_i[0];
    for (int i = 1; i < NUM_AXES; i++) begin
      if (tn_i[i] > near_d) near_d = tn_i[i];
      if (tf_i[i] < far_d)  far_d  = tf_i[i];
      miss_d = miss_d | miss_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    near_q <= near_d;
    far_q  <= far_d;
    miss_q <= miss_d;
    hit_q  <= !miss_q && (near_q <= far_q) && !far_q[CW-1];
  end

  assign hit_o = hit_q;
endmodule

FILE: sv/ray_box_slab_hit_test.sv
// Top level: ray versus axis-aligned box slab hit test.
//  channel | signals                                   | direction
//  command | start, origin/dir/box_min/max_*_i         | in
//  result  | busy, done_o, hit_o                       | out
// One transaction per cycle; done_o and hit_o are valid together, once a transaction clears
// the bit-per-stage divider pipeline in each axis lane and the merge registers.
// busy is always low. Reset clears only the result strobe pipeline.
// The receiver cannot stall; done_o pulses for one cycle per transaction.
module ray_box_slab_hit_test #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_z_i,
  output logic                          done_o,
  output logic                          hit_o
);
  import rbs_pkg::*;

  localparam int unsigned LAT = COORD_WIDTH + FRAC_BITS + 7;

  logic signed [COORD_WIDTH-1:0] o   [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] d   [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] lo  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] hi  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] tn  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] tf  [NUM_AXES];
  logic                          mis [NUM_AXES];
  logic [LAT-1:0]                vld_q;

  assign o  = '{origin_x_i, origin_y_i, origin_z_i};
  assign d  = '{dir_x_i, dir_y_i, dir_z_i};
  assign lo = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi = '{box_max_x_i, box_max_y_i, box_max_z_i};

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbs_lane #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .o_i    (o[a]),
      .d_i    (d[a]),
      .lo_i   (lo[a]),
      .hi_i   (hi[a]),
      .tn_o   (tn[a]),
      .tf_o   (tf[a]),
      .miss_o (mis[a])
    );
  end

  rbs_merge #(.CW(COORD_WIDTH)) u_merge (
    .clk_i  (clk_i),
    .tn_i   (tn),
    .tf_i   (tf),
    .miss_i (mis),
    .hit_o  (hit_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start};
    end
  end

  assign busy   = 1'b0;
  assign done_o = vld_q[LAT-1];
endmodule
